### rtl/sepr_pkg.sv
// shared types, constants and functions for the sha-512 entropy pool generator
`default_nettype none
package sepr_pkg;

    typedef logic [63:0] word_t;
    typedef logic [7:0][63:0] chain_t;
    typedef logic [15:0][63:0] block_t;

    localparam int MAX_REQUEST = 64;
    localparam logic [10:0] CREDIT_CAP = 11'd512;

    localparam logic [7:0] TAG_ABSORB   = 8'h41;
    localparam logic [7:0] TAG_GENERATE = 8'h47;
    localparam logic [7:0] TAG_RATCHET  = 8'h52;

    localparam logic [1:0] RES_DATA   = 2'd0;
    localparam logic [1:0] RES_DONE   = 2'd1;
    localparam logic [1:0] RES_NOTRDY = 2'd2;

    typedef enum logic [1:0] {
        SRC_ABS = 2'd0,
        SRC_GEN = 2'd1,
        SRC_RAT = 2'd2
    } src_t;

    typedef struct packed {
        logic       accept;
        logic       prefix;
        logic       wbyte;
        logic       pad;
        logic       lenblk;
        logic       abs_update;
        logic       abs_fin;
        logic       start;
        src_t       src;
        logic       gen_done;
        logic       rat_done;
        logic       byte_step;
        logic       load_out;
        logic [1:0] out_status;
    } dp_cmd_t;

    typedef struct packed {
        logic cmd_gen;
        logic msg_open;
        logic blk_full;
        logic last;
        logic pad_two;
        logic ready;
        logic req_zero;
        logic core_done;
        logic out_busy;
        logic chunk_end;
        logic req_end;
    } dp_stat_t;

    function automatic word_t rotr(input word_t x, input int r);
        rotr = (x >> r) | (x << (64 - r));
    endfunction

    function automatic word_t sha_iv(input logic [2:0] i);
        unique case (i)
            3'd0: sha_iv = 64'h6a09e667f3bcc908;
            3'd1: sha_iv = 64'hbb67ae8584caa73b;
            3'd2: sha_iv = 64'h3c6ef372fe94f82b;
            3'd3: sha_iv = 64'ha54ff53a5f1d36f1;
            3'd4: sha_iv = 64'h510e527fade682d1;
            3'd5: sha_iv = 64'h9b05688c2b3e6c1f;
            3'd6: sha_iv = 64'h1f83d9abfb41bd6b;
            3'd7: sha_iv = 64'h5be0cd19137e2179;
        endcase
    endfunction

    function automatic chain_t sha_iv_chain();
        chain_t c;
        for (int i = 0; i < 8; i++)
        begin
            c[i] = sha_iv(3'(i));
        end
        return c;
    endfunction

    function automatic word_t kround(input logic [6:0] i);
        unique case (i)
            7'd0:  kround = 64'h428a2f98d728ae22;
            7'd1:  kround = 64'h7137449123ef65cd;
            7'd2:  kround = 64'hb5c0fbcfec4d3b2f;
            7'd3:  kround = 64'he9b5dba58189dbbc;
            7'd4:  kround = 64'h3956c25bf348b538;
            7'd5:  kround = 64'h59f111f1b605d019;
            7'd6:  kround = 64'h923f82a4af194f9b;
            7'd7:  kround = 64'hab1c5ed5da6d8118;
            7'd8:  kround = 64'hd807aa98a3030242;
            7'd9:  kround = 64'h12835b0145706fbe;
            7'd10: kround = 64'h243185be4ee4b28c;
            7'd11: kround = 64'h550c7dc3d5ffb4e2;
            7'd12: kround = 64'h72be5d74f27b896f;
            7'd13: kround = 64'h80deb1fe3b1696b1;
            7'd14: kround = 64'h9bdc06a725c71235;
            7'd15: kround = 64'hc19bf174cf692694;
            7'd16: kround = 64'he49b69c19ef14ad2;
            7'd17: kround = 64'hefbe4786384f25e3;
            7'd18: kround = 64'h0fc19dc68b8cd5b5;
            7'd19: kround = 64'h240ca1cc77ac9c65;
            7'd20: kround = 64'h2de92c6f592b0275;
            7'd21: kround = 64'h4a7484aa6ea6e483;
            7'd22: kround = 64'h5cb0a9dcbd41fbd4;
            7'd23: kround = 64'h76f988da831153b5;
            7'd24: kround = 64'h983e5152ee66dfab;
            7'd25: kround = 64'ha831c66d2db43210;
            7'd26: kround = 64'hb00327c898fb213f;
            7'd27: kround = 64'hbf597fc7beef0ee4;
            7'd28: kround = 64'hc6e00bf33da88fc2;
            7'd29: kround = 64'hd5a79147930aa725;
            7'd30: kround = 64'h06ca6351e003826f;
            7'd31: kround = 64'h142929670a0e6e70;
            7'd32: kround = 64'h27b70a8546d22ffc;
            7'd33: kround = 64'h2e1b21385c26c926;
            7'd34: kround = 64'h4d2c6dfc5ac42aed;
            7'd35: kround = 64'h53380d139d95b3df;
            7'd36: kround = 64'h650a73548baf63de;
            7'd37: kround = 64'h766a0abb3c77b2a8;
            7'd38: kround = 64'h81c2c92e47edaee6;
            7'd39: kround = 64'h92722c851482353b;
            7'd40: kround = 64'ha2bfe8a14cf10364;
            7'd41: kround = 64'ha81a664bbc423001;
            7'd42: kround = 64'hc24b8b70d0f89791;
            7'd43: kround = 64'hc76c51a30654be30;
            7'd44: kround = 64'hd192e819d6ef5218;
            7'd45: kround = 64'hd69906245565a910;
            7'd46: kround = 64'hf40e35855771202a;
            7'd47: kround = 64'h106aa07032bbd1b8;
            7'd48: kround = 64'h19a4c116b8d2d0c8;
            7'd49: kround = 64'h1e376c085141ab53;
            7'd50: kround = 64'h2748774cdf8eeb99;
            7'd51: kround = 64'h34b0bcb5e19b48a8;
            7'd52: kround = 64'h391c0cb3c5c95a63;
            7'd53: kround = 64'h4ed8aa4ae3418acb;
            7'd54: kround = 64'h5b9cca4f7763e373;
            7'd55: kround = 64'h682e6ff3d6b2b8a3;
            7'd56: kround = 64'h748f82ee5defb2fc;
            7'd57: kround = 64'h78a5636f43172f60;
            7'd58: kround = 64'h84c87814a1f0ab72;
            7'd59: kround = 64'h8cc702081a6439ec;
            7'd60: kround = 64'h90befffa23631e28;
            7'd61: kround = 64'ha4506cebde82bde9;
            7'd62: kround = 64'hbef9a3f7b2c67915;
            7'd63: kround = 64'hc67178f2e372532b;
            7'd64: kround = 64'hca273eceea26619c;
            7'd65: kround = 64'hd186b8c721c0c207;
            7'd66: kround = 64'heada7dd6cde0eb1e;
            7'd67: kround = 64'hf57d4f7fee6ed178;
            7'd68: kround = 64'h06f067aa72176fba;
            7'd69: kround = 64'h0a637dc5a2c898a6;
            7'd70: kround = 64'h113f9804bef90dae;
            7'd71: kround = 64'h1b710b35131c471b;
            7'd72: kround = 64'h28db77f523047d84;
            7'd73: kround = 64'h32caab7b40c72493;
            7'd74: kround = 64'h3c9ebe0a15c9bebc;
            7'd75: kround = 64'h431d67c49c100d4c;
            7'd76: kround = 64'h4cc5d4becb3e42b6;
            7'd77: kround = 64'h597f299cfc657e2a;
            7'd78: kround = 64'h5fcb6fab3ad6faec;
            7'd79: kround = 64'h6c44198c4a475817;
            default: kround = 64'h0;
        endcase
    endfunction

    // tag byte, then the 64 pool bytes, then the fixed tail of the message kind
    function automatic block_t build_block(input src_t src, input chain_t pool,
                                           input logic [31:0] ctr);
        block_t b;
        logic [7:0] tag;
        b = '0;
        unique case (src)
            SRC_GEN: tag = TAG_GENERATE;
            SRC_RAT: tag = TAG_RATCHET;
            default: tag = TAG_ABSORB;
        endcase
        b[0] = {tag, pool[0][63:8]};
        for (int k = 1; k < 8; k++)
        begin
            b[k] = {pool[k-1][7:0], pool[k][63:8]};
        end
        unique case (src)
            SRC_GEN:
            begin
                b[8]  = {pool[7][7:0], ctr, 8'h80, 16'h0};
                b[15] = 64'd552;
            end
            SRC_RAT:
            begin
                b[8]  = {pool[7][7:0], 8'h80, 48'h0};
                b[15] = 64'd520;
            end
            default:
            begin
                b[8] = {pool[7][7:0], 56'h0};
            end
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

### rtl/sepr_sha_core.sv
// iterative sha-512 compression, one round per cycle
`default_nettype none
module sepr_sha_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire sepr_pkg::chain_t chain_in,
    input  wire sepr_pkg::block_t block_in,
    output logic                 done,
    output sepr_pkg::chain_t     digest
);
    import sepr_pkg::*;

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [6:0] cnt_reg, cnt_next;
    chain_t     base_reg;
    chain_t     wk_reg;
    block_t     s_reg;
    chain_t     dig_reg;

    word_t t1, t2, s_new;
    word_t a, b, c, d, e, f, g, h, x, y;

    always_comb
    begin
        a = wk_reg[0]; b = wk_reg[1]; c = wk_reg[2]; d = wk_reg[3];
        e = wk_reg[4]; f = wk_reg[5]; g = wk_reg[6]; h = wk_reg[7];
        x = s_reg[1];
        y = s_reg[14];
        t1 = h + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41)) + ((e & f) ^ (~e & g))
           + kround(cnt_reg) + s_reg[0];
        t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
        s_new = s_reg[0] + (rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7)) + s_reg[9]
              + (rotr(y, 19) ^ rotr(y, 61) ^ (y >> 6));
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 7'd80)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            base_reg <= chain_in;
            wk_reg   <= chain_in;
            s_reg    <= block_in;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 7'd80)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    dig_reg[i] <= base_reg[i] + wk_reg[i];
                end
            end
            else
            begin
                wk_reg <= {g, f, e, d + t1, c, b, a, t1 + t2};
                for (int j = 0; j < 15; j++)
                begin
                    s_reg[j] <= s_reg[j+1];
                end
                s_reg[15] <= s_new;
            end
        end
    end

    assign done   = done_reg;
    assign digest = dig_reg;

endmodule
`default_nettype wire

### rtl/sepr_datapath.sv
// pool, credit, counter, message buffer, hash core and result register
`default_nettype none
module sepr_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sepr_pkg::dp_cmd_t cmd,
    output sepr_pkg::dp_stat_t     stat,
    input  wire logic              in_command,
    input  wire logic [7:0]        in_data_byte,
    input  wire logic              in_last_byte,
    input  wire logic [9:0]        in_entropy_bits,
    input  wire logic [6:0]        in_request_length,
    input  wire logic              cfg_we,
    input  wire logic [9:0]        cfg_value,
    input  wire logic              out_taken,
    output logic                   out_valid,
    output logic [7:0]             out_random_byte,
    output logic [1:0]             out_status,
    output logic                   out_last,
    output logic [9:0]             out_credited_bits,
    output logic                   out_ready_res
);
    import sepr_pkg::*;

    chain_t      pool_reg;
    logic [9:0]  credit_reg, credit_next;
    logic [31:0] ctr_reg;
    logic [63:0] len_reg;
    logic [9:0]  min_reg;
    chain_t      h_reg;
    block_t      w_reg;
    chain_t      gdig_reg;

    logic        cmd_reg, last_reg;
    logic [7:0]  byte_reg;
    logic [9:0]  bits_reg;
    logic [6:0]  req_reg;
    logic [6:0]  done_cnt_reg;
    logic [4:0]  ci_reg;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [1:0]  out_status_reg;
    logic        out_last_reg;
    logic [9:0]  out_credit_reg;
    logic        out_ready_reg;

    logic [6:0]  idx;
    logic [3:0]  wi;
    logic [5:0]  sh;
    logic [6:0]  req_clamp;
    logic [10:0] credit_sum;
    logic        ready_now;
    logic        req_end;
    logic [7:0]  gen_byte;
    chain_t      core_chain;
    block_t      core_block;
    logic        core_done;
    chain_t      core_digest;
    block_t      pad_blk;
    block_t      len_blk;

    assign idx = len_reg[6:0];
    assign wi  = idx[6:3];
    assign sh  = {~idx[2:0], 3'b000};
    assign req_clamp = ({25'd0, in_request_length} > MAX_REQUEST)
                     ? MAX_REQUEST[6:0] : in_request_length;
    assign credit_sum = {1'b0, credit_reg} + {1'b0, bits_reg};
    assign ready_now  = credit_reg >= min_reg;
    assign req_end    = (done_cnt_reg + 7'd1) == req_reg;
    assign gen_byte   = 8'(gdig_reg[{1'b0, ci_reg[4:3]}] >> {~ci_reg[2:0], 3'b000});

    assign core_chain = (cmd.src == SRC_ABS) ? h_reg : sha_iv_chain();
    assign core_block = (cmd.src == SRC_ABS) ? w_reg : build_block(cmd.src, pool_reg, ctr_reg);

    sepr_sha_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start),
        .chain_in (core_chain),
        .block_in (core_block),
        .done     (core_done),
        .digest   (core_digest)
    );

    always_comb
    begin
        credit_next = credit_reg;
        if (bits_reg != 10'd0)
        begin
            credit_next = (credit_sum > CREDIT_CAP) ? CREDIT_CAP[9:0] : credit_sum[9:0];
        end
    end

    // padded block and trailing length block
    always_comb
    begin
        pad_blk = w_reg;
        for (int j = 0; j < 16; j++)
        begin
            if (4'(j) > wi)
            begin
                pad_blk[j] = 64'd0;
            end
        end
        pad_blk[wi] = ((idx[2:0] == 3'd0) ? 64'd0 : w_reg[wi]) | (64'h80 << sh);
        if (wi < 4'd14)
        begin
            pad_blk[14] = {61'd0, len_reg[63:61]};
            pad_blk[15] = {len_reg[60:0], 3'b000};
        end
        len_blk     = '0;
        len_blk[14] = {61'd0, len_reg[63:61]};
        len_blk[15] = {len_reg[60:0], 3'b000};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg      <= '0;
            credit_reg    <= 10'd0;
            ctr_reg       <= 32'd0;
            len_reg       <= 64'd0;
            min_reg       <= 10'd256;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_reg <= cfg_value;
            end
            if (cmd.prefix)
            begin
                len_reg <= 64'd65;
            end
            else if (cmd.wbyte)
            begin
                len_reg <= len_reg + 64'd1;
            end
            else if (cmd.abs_fin)
            begin
                len_reg <= 64'd0;
            end
            if (cmd.abs_fin)
            begin
                pool_reg   <= h_reg;
                credit_reg <= credit_next;
            end
            else if (cmd.rat_done)
            begin
                pool_reg <= core_digest;
            end
            if (cmd.gen_done)
            begin
                ctr_reg <= ctr_reg + 32'd1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg  <= in_command;
            byte_reg <= in_data_byte;
            last_reg <= in_last_byte;
            bits_reg <= in_entropy_bits;
            req_reg  <= req_clamp;
            done_cnt_reg <= 7'd0;
        end
        else if (cmd.byte_step)
        begin
            done_cnt_reg <= done_cnt_reg + 7'd1;
        end
        if (cmd.gen_done)
        begin
            gdig_reg <= core_digest;
            ci_reg   <= 5'd0;
        end
        else if (cmd.byte_step)
        begin
            ci_reg <= ci_reg + 5'd1;
        end
        if (cmd.prefix)
        begin
            h_reg <= sha_iv_chain();
        end
        else if (cmd.abs_update)
        begin
            h_reg <= core_digest;
        end
        if (cmd.prefix)
        begin
            w_reg <= build_block(SRC_ABS, pool_reg, ctr_reg);
        end
        else if (cmd.wbyte)
        begin
            w_reg[wi] <= ((idx[2:0] == 3'd0) ? 64'd0 : w_reg[wi])
                       | ({56'd0, byte_reg} << sh);
        end
        else if (cmd.pad)
        begin
            w_reg <= pad_blk;
        end
        else if (cmd.lenblk)
        begin
            w_reg <= len_blk;
        end
        if (cmd.load_out)
        begin
            out_byte_reg   <= (cmd.out_status == RES_DATA) ? gen_byte : 8'd0;
            out_status_reg <= cmd.out_status;
            out_last_reg   <= (cmd.out_status == RES_DATA) ? req_end : 1'b1;
            out_credit_reg <= credit_reg;
            out_ready_reg  <= ready_now;
        end
    end

    always_comb
    begin
        stat.cmd_gen   = cmd_reg;
        stat.msg_open  = len_reg != 64'd0;
        stat.blk_full  = idx == 7'd127;
        stat.last      = last_reg;
        stat.pad_two   = wi >= 4'd14;
        stat.ready     = ready_now;
        stat.req_zero  = req_reg == 7'd0;
        stat.core_done = core_done;
        stat.out_busy  = out_valid_reg;
        stat.chunk_end = ci_reg == 5'd31;
        stat.req_end   = req_end;
    end

    assign out_valid         = out_valid_reg;
    assign out_random_byte   = out_byte_reg;
    assign out_status        = out_status_reg;
    assign out_last          = out_last_reg;
    assign out_credited_bits = out_credit_reg;
    assign out_ready_res     = out_ready_reg;

endmodule
`default_nettype wire

### rtl/sepr_ctrl.sv
// controller state machine sequencing absorb, generate and ratchet
`default_nettype none
module sepr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sepr_pkg::dp_stat_t stat,
    output sepr_pkg::dp_cmd_t      cmd
);
    import sepr_pkg::*;

    typedef enum logic [19:0] {
        S_IDLE    = 20'h00001,
        S_DISP    = 20'h00002,
        S_ABYTE   = 20'h00004,
        S_BSTART  = 20'h00008,
        S_BWAIT   = 20'h00010,
        S_TAIL    = 20'h00020,
        S_PSTART  = 20'h00040,
        S_PWAIT   = 20'h00080,
        S_LEN     = 20'h00100,
        S_LSTART  = 20'h00200,
        S_LWAIT   = 20'h00400,
        S_FIN     = 20'h00800,
        S_DONEOUT = 20'h01000,
        S_RESP    = 20'h02000,
        S_GSTART  = 20'h04000,
        S_GWAIT   = 20'h08000,
        S_ELOAD   = 20'h10000,
        S_EWAIT   = 20'h20000,
        S_RSTART  = 20'h40000,
        S_RWAIT   = 20'h80000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        cmd = '0;
        cmd.src = SRC_ABS;
        cmd.out_status = RES_DONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (stat.cmd_gen)
                begin
                    if (!stat.ready)
                    begin
                        cmd.load_out   = 1'b1;
                        cmd.out_status = RES_NOTRDY;
                        state_next     = S_RESP;
                    end
                    else if (stat.req_zero)
                    begin
                        state_next = S_RSTART;
                    end
                    else
                    begin
                        state_next = S_GSTART;
                    end
                end
                else
                begin
                    cmd.prefix = !stat.msg_open;
                    state_next = S_ABYTE;
                end
            end
            S_ABYTE:
            begin
                cmd.wbyte  = 1'b1;
                state_next = stat.blk_full ? S_BSTART : S_TAIL;
            end
            S_BSTART:
            begin
                cmd.start  = 1'b1;
                state_next = S_BWAIT;
            end
            S_BWAIT:
            begin
                if (stat.core_done)
                begin
                    cmd.abs_update = 1'b1;
                    state_next     = S_TAIL;
                end
            end
            S_TAIL:
            begin
                if (stat.last)
                begin
                    cmd.pad    = 1'b1;
                    state_next = S_PSTART;
                end
                else
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_RESP;
                end
            end
            S_PSTART:
            begin
                cmd.start  = 1'b1;
                state_next = S_PWAIT;
            end
            S_PWAIT:
            begin
                if (stat.core_done)
                begin
                    cmd.abs_update = 1'b1;
                    state_next     = stat.pad_two ? S_LEN : S_FIN;
                end
            end
            S_LEN:
            begin
                cmd.lenblk = 1'b1;
                state_next = S_LSTART;
            end
            S_LSTART:
            begin
                cmd.start  = 1'b1;
                state_next = S_LWAIT;
            end
            S_LWAIT:
            begin
                if (stat.core_done)
                begin
                    cmd.abs_update = 1'b1;
                    state_next     = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.abs_fin = 1'b1;
                state_next  = S_DONEOUT;
            end
            S_DONEOUT:
            begin
                cmd.load_out = 1'b1;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_GSTART:
            begin
                cmd.start  = 1'b1;
                cmd.src    = SRC_GEN;
                state_next = S_GWAIT;
            end
            S_GWAIT:
            begin
                if (stat.core_done)
                begin
                    cmd.gen_done = 1'b1;
                    state_next   = S_ELOAD;
                end
            end
            S_ELOAD:
            begin
                cmd.load_out   = 1'b1;
                cmd.out_status = RES_DATA;
                state_next     = S_EWAIT;
            end
            S_EWAIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.byte_step = 1'b1;
                    if (stat.req_end)
                    begin
                        state_next = S_RSTART;
                    end
                    else if (stat.chunk_end)
                    begin
                        state_next = S_GSTART;
                    end
                    else
                    begin
                        state_next = S_ELOAD;
                    end
                end
            end
            S_RSTART:
            begin
                cmd.start  = 1'b1;
                cmd.src    = SRC_RAT;
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (stat.core_done)
                begin
                    cmd.rat_done = 1'b1;
                    state_next   = stat.req_zero ? S_DONEOUT : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

### rtl/sha512_entropy_pool_rng.sv
// top level of the sha-512 entropy pool random byte generator
`default_nettype none
// Takes one word at a time. A word that fills a 128-byte block adds one
// compression, and the last word of a message adds one or two (each: start,
// 80 rounds of the single shared round unit, final add and done). A ready
// generate of n bytes costs ceil(n/32) compressions and one ratchet
// compression and puts out each byte only after the previous one was taken;
// a not-ready generate answers without any compression. The block accepts a
// new word only after every result of the previous one has been taken.
// The threshold register may be written at any time the block is idle.
module sha512_entropy_pool_rng (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // data_byte, entropy_bits, request_length
    input  wire logic [0:0]  s_axis_tuser,   // command
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // random_byte, credited_bits, ready_res
    output logic [1:0]       m_axis_tuser,   // status
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [9:0]  cfg_data
);
    import sepr_pkg::*;

    dp_cmd_t    cmd;
    dp_stat_t   stat;
    logic [7:0] rbyte;
    logic [9:0] credit;
    logic       rdy;

    assign cfg_ready = 1'b1;

    sepr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sepr_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .in_command        (s_axis_tuser[0]),
        .in_data_byte      (s_axis_tdata[7:0]),
        .in_last_byte      (s_axis_tlast),
        .in_entropy_bits   (s_axis_tdata[17:8]),
        .in_request_length (s_axis_tdata[24:18]),
        .cfg_we            (cfg_valid),
        .cfg_value         (cfg_data),
        .out_taken         (m_axis_tready),
        .out_valid         (m_axis_tvalid),
        .out_random_byte   (rbyte),
        .out_status        (m_axis_tuser),
        .out_last          (m_axis_tlast),
        .out_credited_bits (credit),
        .out_ready_res     (rdy)
    );

    assign m_axis_tdata = {5'd0, rdy, credit, rbyte};

endmodule
`default_nettype wire
